// ===== rtl/dcepm_pkg.sv =====
// dcepm_pkg: shared constants, register index codes and reset defaults
// for the dual channel moving average and peak monitor
// no dependencies
package dcepm_pkg;

   localparam int SAMPLE_WIDTH_DEF  = 16;
   localparam int FRACTION_BITS_DEF = 24;

   localparam int ALPHA_W     = 24;
   localparam int THRESHOLD_W = 15;
   localparam int CSR_DATA_W  = 24;
   localparam int CSR_INDEX_W = 3;

   localparam int NUM_CHANNELS = 2;
   localparam int NUM_AVERAGES = 3;
   localparam int NUM_SAMPLES  = 4;
   localparam int NUM_LANE_OUT = 4;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_AVERAGING_ENABLE = 3'd0;
   localparam csr_index_type CSR_REPORT_CHANNEL   = 3'd1;
   localparam csr_index_type CSR_CHANGE_THRESHOLD = 3'd2;
   localparam csr_index_type CSR_ALPHA_SHORT      = 3'd3;
   localparam csr_index_type CSR_ALPHA_MEDIUM     = 3'd4;
   localparam csr_index_type CSR_ALPHA_LONG       = 3'd5;

   // order of averages inside a lane
   localparam int AVG_SHORT  = 0;
   localparam int AVG_MEDIUM = 1;
   localparam int AVG_LONG   = 2;

   // order of the values a lane hands to the merge stage
   localparam int LANE_SHORT  = 0;
   localparam int LANE_MEDIUM = 1;
   localparam int LANE_LONG   = 2;
   localparam int LANE_PEAK   = 3;

   // order of the sample words in one input word
   localparam int SMP_CURRENT_A = 0;
   localparam int SMP_CURRENT_B = 1;
   localparam int SMP_VOLTAGE_A = 2;
   localparam int SMP_VOLTAGE_B = 3;

   localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET    = 15'd5;
   localparam logic [ALPHA_W-1:0]     ALPHA_SHORT_RESET  = 24'd5033165;
   localparam logic [ALPHA_W-1:0]     ALPHA_MEDIUM_RESET = 24'd33554;
   localparam logic [ALPHA_W-1:0]     ALPHA_LONG_RESET   = 24'd554;

endpackage

// ===== rtl/dcepm_ema_unit.sv =====
// dcepm_ema_unit: one moving average step, avg + floor(alpha * (x - avg))
// uses dcepm_pkg for the alpha width
module dcepm_ema_unit #(
   parameter int SAMPLE_WIDTH  = dcepm_pkg::SAMPLE_WIDTH_DEF,
   parameter int FRACTION_BITS = dcepm_pkg::FRACTION_BITS_DEF
) (
   input  logic [SAMPLE_WIDTH+FRACTION_BITS-1:0] avg_cur,
   input  logic [dcepm_pkg::ALPHA_W-1:0]         alpha,
   input  logic [SAMPLE_WIDTH-1:0]               sample,
   output logic [SAMPLE_WIDTH+FRACTION_BITS-1:0] avg_next
);
   import dcepm_pkg::*;

   localparam int AW     = SAMPLE_WIDTH + FRACTION_BITS;
   localparam int LO_W   = (AW + 1) / 2;
   localparam int HI_W   = AW - LO_W;
   localparam int PLO_W  = ALPHA_W + LO_W;
   localparam int PHI_W  = ALPHA_W + HI_W;
   localparam int PROD_W = ALPHA_W + AW;

   logic [AW-1:0]     xs;
   logic [AW:0]       diff;
   logic [AW:0]       neg_diff;
   logic              down;
   logic [AW-1:0]     mag;
   logic [LO_W-1:0]   mag_lo;
   logic [HI_W-1:0]   mag_hi;
   logic [PLO_W-1:0]  prod_lo;
   logic [PHI_W-1:0]  prod_hi;
   logic [PROD_W-1:0] prod;
   logic [AW-1:0]     step;
   logic              rem;

   assign xs       = {sample, {FRACTION_BITS{1'b0}}};
   assign diff     = {xs[AW-1], xs} - {avg_cur[AW-1], avg_cur};
   assign neg_diff = (AW+1)'(0) - diff;
   assign down     = diff[AW];
   assign mag      = down ? neg_diff[AW-1:0] : diff[AW-1:0];
   assign mag_lo   = mag[LO_W-1:0];
   assign mag_hi   = mag[AW-1:LO_W];

   // product split in two halves to keep each multiplier narrow
   assign prod_lo = PLO_W'(alpha) * PLO_W'(mag_lo);
   assign prod_hi = PHI_W'(alpha) * PHI_W'(mag_hi);
   assign prod    = (PROD_W'(prod_hi) << LO_W) + PROD_W'(prod_lo);

   assign step = prod[PROD_W-1:ALPHA_W];
   assign rem  = |prod[ALPHA_W-1:0];

   // floor toward minus infinity: a step down rounds its magnitude up
   assign avg_next = down ? (avg_cur - step - AW'(rem)) : (avg_cur + step);

endmodule

// ===== rtl/dcepm_chan_lane.sv =====
// dcepm_chan_lane: one channel's three moving averages and peak hold
// uses dcepm_pkg and dcepm_ema_unit
module dcepm_chan_lane #(
   parameter int SAMPLE_WIDTH  = dcepm_pkg::SAMPLE_WIDTH_DEF,
   parameter int FRACTION_BITS = dcepm_pkg::FRACTION_BITS_DEF
) (
   input  logic                                                  clock,
   input  logic                                                  reset,
   input  logic                                                  update,
   input  logic [dcepm_pkg::NUM_AVERAGES-1:0][dcepm_pkg::ALPHA_W-1:0] alphas,
   input  logic [SAMPLE_WIDTH-1:0]                               sample,
   output logic [dcepm_pkg::NUM_LANE_OUT-1:0][SAMPLE_WIDTH-1:0]  lane_values
);
   import dcepm_pkg::*;

   localparam int AW = SAMPLE_WIDTH + FRACTION_BITS;

   logic [NUM_AVERAGES-1:0][AW-1:0] avg_ff;
   logic [NUM_AVERAGES-1:0][AW-1:0] avg_in;
   logic [NUM_AVERAGES-1:0][AW-1:0] avg_step;
   logic signed [SAMPLE_WIDTH-1:0]  peak_ff;
   logic signed [SAMPLE_WIDTH-1:0]  peak_in;
   logic signed [SAMPLE_WIDTH-1:0]  sample_s;

   assign sample_s = sample;

   for (genvar g = 0; g < NUM_AVERAGES; g++) begin : g_avg
      dcepm_ema_unit #(
         .SAMPLE_WIDTH  (SAMPLE_WIDTH),
         .FRACTION_BITS (FRACTION_BITS)
      ) u_ema (
         .avg_cur  (avg_ff[g]),
         .alpha    (alphas[g]),
         .sample   (sample),
         .avg_next (avg_step[g])
      );
   end

   always_comb begin
      avg_in  = update ? avg_step : avg_ff;
      peak_in = (update && (sample_s > peak_ff)) ? sample_s : peak_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_ff  <= '0;
         peak_ff <= '0;
      end else begin
         avg_ff  <= avg_in;
         peak_ff <= peak_in;
      end
   end

   // results reflect the state after this word, integer part is the top bits
   assign lane_values[LANE_SHORT]  = avg_in[AVG_SHORT][AW-1:FRACTION_BITS];
   assign lane_values[LANE_MEDIUM] = avg_in[AVG_MEDIUM][AW-1:FRACTION_BITS];
   assign lane_values[LANE_LONG]   = avg_in[AVG_LONG][AW-1:FRACTION_BITS];
   assign lane_values[LANE_PEAK]   = peak_in;

endmodule

// ===== rtl/dcepm_merge.sv =====
// dcepm_merge: change detection against the reported set, and selection
// of one lane's averages and peak for the result; uses dcepm_pkg
module dcepm_merge #(
   parameter int SAMPLE_WIDTH = dcepm_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                                                  clock,
   input  logic                                                  reset,
   input  logic                                                  accept,
   input  logic                                                  force_refresh,
   input  logic [dcepm_pkg::THRESHOLD_W-1:0]                     threshold,
   input  logic                                                  report_channel,
   input  logic [dcepm_pkg::NUM_SAMPLES-1:0][SAMPLE_WIDTH-1:0]   samples,
   input  logic [dcepm_pkg::NUM_CHANNELS-1:0][dcepm_pkg::NUM_LANE_OUT-1:0][SAMPLE_WIDTH-1:0]
                                                                 lane_values,
   output logic                                                  update_flag,
   output logic [dcepm_pkg::NUM_SAMPLES-1:0][SAMPLE_WIDTH-1:0]   shown,
   output logic [dcepm_pkg::NUM_LANE_OUT-1:0][SAMPLE_WIDTH-1:0]  selected
);
   import dcepm_pkg::*;

   localparam int CMP_W = (SAMPLE_WIDTH > THRESHOLD_W) ? SAMPLE_WIDTH : THRESHOLD_W;

   logic [NUM_SAMPLES-1:0][SAMPLE_WIDTH-1:0] reported_ff;
   logic [NUM_SAMPLES-1:0][SAMPLE_WIDTH-1:0] reported_in;
   logic [NUM_SAMPLES-1:0]                   exceeds;

   always_comb begin
      logic [SAMPLE_WIDTH:0]   diff;
      logic [SAMPLE_WIDTH:0]   neg_diff;
      logic [SAMPLE_WIDTH-1:0] gap;
      for (int i = 0; i < NUM_SAMPLES; i++) begin
         diff       = {samples[i][SAMPLE_WIDTH-1], samples[i]}
                    - {reported_ff[i][SAMPLE_WIDTH-1], reported_ff[i]};
         neg_diff   = (SAMPLE_WIDTH+1)'(0) - diff;
         gap        = diff[SAMPLE_WIDTH] ? neg_diff[SAMPLE_WIDTH-1:0]
                                         : diff[SAMPLE_WIDTH-1:0];
         exceeds[i] = CMP_W'(gap) > CMP_W'(threshold);
      end
      update_flag = force_refresh || (|exceeds);
      reported_in = update_flag ? samples : reported_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reported_ff <= '0;
      end else if (accept) begin
         reported_ff <= reported_in;
      end
   end

   assign shown    = reported_in;
   assign selected = lane_values[report_channel];

endmodule

// ===== rtl/dcepm_rsp_skid.sv =====
// dcepm_rsp_skid: two entry result buffer between the datapath and the
// result channel; no package dependencies
module dcepm_rsp_skid #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   output logic              out_valid,
   input  logic              out_stall,
   output logic [DATA_W-1:0] out_data
);

   logic              main_valid_ff;
   logic              main_valid_in;
   logic [DATA_W-1:0] main_data_ff;
   logic [DATA_W-1:0] main_data_in;
   logic              spare_valid_ff;
   logic              spare_valid_in;
   logic [DATA_W-1:0] spare_data_ff;
   logic [DATA_W-1:0] spare_data_in;
   logic              drain;

   assign drain = main_valid_ff && !out_stall;

   always_comb begin
      main_valid_in  = main_valid_ff;
      main_data_in   = main_data_ff;
      spare_valid_in = spare_valid_ff;
      spare_data_in  = spare_data_ff;
      if (spare_valid_ff) begin
         // no push while the spare is taken
         if (drain) begin
            main_data_in   = spare_data_ff;
            spare_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || drain) begin
            main_valid_in = 1'b1;
            main_data_in  = push_data;
         end else begin
            spare_valid_in = 1'b1;
            spare_data_in  = push_data;
         end
      end else if (drain) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff  <= 1'b0;
         spare_valid_ff <= 1'b0;
      end else begin
         main_valid_ff  <= main_valid_in;
         spare_valid_ff <= spare_valid_in;
      end
      main_data_ff  <= main_data_in;
      spare_data_ff <= spare_data_in;
   end

   assign full      = spare_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

endmodule

// ===== rtl/dual_channel_ema_peak_monitor_top.sv =====
// channel   ports             handshake                 moves
// req       req_*             req_valid / req_stall     one sample word, both channels
// rsp       rsp_*             rsp_valid / rsp_stall     one result word per sample word
// csr       csr_*             csr_write                 one register write, no read-back
//
// one sample word per cycle while req_stall is low; each result is registered in the result buffer.
// the rate is set by each lane's average recurrence: subtract,
// two half-width alpha products, add, all closing back into the average register.
// reset (synchronous) zeroes averages, peaks and the reported set, and loads
// register defaults; no clearing pass. a two-entry result buffer absorbs
// rsp_stall, and req_stall rises only when both entries hold results.
//
// top level of the dual channel moving average and peak monitor
// uses dcepm_pkg, dcepm_chan_lane, dcepm_merge, dcepm_rsp_skid
module dual_channel_ema_peak_monitor_top #(
   parameter int SAMPLE_WIDTH  = dcepm_pkg::SAMPLE_WIDTH_DEF,
   parameter int FRACTION_BITS = dcepm_pkg::FRACTION_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]      req_current_a,
   input  logic signed [SAMPLE_WIDTH-1:0]      req_current_b,
   input  logic signed [SAMPLE_WIDTH-1:0]      req_voltage_a,
   input  logic signed [SAMPLE_WIDTH-1:0]      req_voltage_b,
   input  logic                                req_force_refresh,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_update_flag,
   output logic signed [SAMPLE_WIDTH-1:0]      rsp_shown_current_a,
   output logic signed [SAMPLE_WIDTH-1:0]      rsp_shown_current_b,
   output logic signed [SAMPLE_WIDTH-1:0]      rsp_shown_voltage_a,
   output logic signed [SAMPLE_WIDTH-1:0]      rsp_shown_voltage_b,
   output logic signed [SAMPLE_WIDTH-1:0]      rsp_short_average,
   output logic signed [SAMPLE_WIDTH-1:0]      rsp_medium_average,
   output logic signed [SAMPLE_WIDTH-1:0]      rsp_long_average,
   output logic signed [SAMPLE_WIDTH-1:0]      rsp_peak_current,

   input  logic                                csr_write,
   input  logic [dcepm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [dcepm_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import dcepm_pkg::*;

   localparam int RSP_W = 1 + (NUM_SAMPLES + NUM_LANE_OUT) * SAMPLE_WIDTH;

   logic                   enable_ff;
   logic                   channel_ff;
   logic [THRESHOLD_W-1:0] threshold_ff;
   logic [ALPHA_W-1:0]     alpha_short_ff;
   logic [ALPHA_W-1:0]     alpha_medium_ff;
   logic [ALPHA_W-1:0]     alpha_long_ff;

   logic accept;
   logic lane_update;

   logic [NUM_AVERAGES-1:0][ALPHA_W-1:0]                     alphas;
   logic [NUM_SAMPLES-1:0][SAMPLE_WIDTH-1:0]                 samples;
   logic [NUM_CHANNELS-1:0][NUM_LANE_OUT-1:0][SAMPLE_WIDTH-1:0] lane_values;

   logic                                     update_flag;
   logic [NUM_SAMPLES-1:0][SAMPLE_WIDTH-1:0] shown;
   logic [NUM_LANE_OUT-1:0][SAMPLE_WIDTH-1:0] selected;
   logic [RSP_W-1:0]                         rsp_word;
   logic [RSP_W-1:0]                         rsp_data;
   logic                                     rsp_update;
   logic [NUM_SAMPLES-1:0][SAMPLE_WIDTH-1:0] rsp_shown;
   logic [NUM_LANE_OUT-1:0][SAMPLE_WIDTH-1:0] rsp_selected;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff       <= 1'b0;
         channel_ff      <= 1'b0;
         threshold_ff    <= THRESHOLD_RESET;
         alpha_short_ff  <= ALPHA_SHORT_RESET;
         alpha_medium_ff <= ALPHA_MEDIUM_RESET;
         alpha_long_ff   <= ALPHA_LONG_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_AVERAGING_ENABLE: enable_ff       <= csr_wdata[0];
            CSR_REPORT_CHANNEL:   channel_ff      <= csr_wdata[0];
            CSR_CHANGE_THRESHOLD: threshold_ff    <= csr_wdata[THRESHOLD_W-1:0];
            CSR_ALPHA_SHORT:      alpha_short_ff  <= csr_wdata[ALPHA_W-1:0];
            CSR_ALPHA_MEDIUM:     alpha_medium_ff <= csr_wdata[ALPHA_W-1:0];
            CSR_ALPHA_LONG:       alpha_long_ff   <= csr_wdata[ALPHA_W-1:0];
            default: ;
         endcase
      end
   end

   assign accept      = req_valid && !req_stall;
   assign lane_update = accept && enable_ff;

   assign alphas[AVG_SHORT]  = alpha_short_ff;
   assign alphas[AVG_MEDIUM] = alpha_medium_ff;
   assign alphas[AVG_LONG]   = alpha_long_ff;

   assign samples[SMP_CURRENT_A] = req_current_a;
   assign samples[SMP_CURRENT_B] = req_current_b;
   assign samples[SMP_VOLTAGE_A] = req_voltage_a;
   assign samples[SMP_VOLTAGE_B] = req_voltage_b;

   // one lane per channel, fed with that channel's current
   for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_lane
      dcepm_chan_lane #(
         .SAMPLE_WIDTH  (SAMPLE_WIDTH),
         .FRACTION_BITS (FRACTION_BITS)
      ) u_lane (
         .clock       (clock),
         .reset       (reset),
         .update      (lane_update),
         .alphas      (alphas),
         .sample      (samples[SMP_CURRENT_A + c]),
         .lane_values (lane_values[c])
      );
   end

   dcepm_merge #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_merge (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .force_refresh  (req_force_refresh),
      .threshold      (threshold_ff),
      .report_channel (channel_ff),
      .samples        (samples),
      .lane_values    (lane_values),
      .update_flag    (update_flag),
      .shown          (shown),
      .selected       (selected)
   );

   assign rsp_word = {update_flag, shown, selected};

   dcepm_rsp_skid #(
      .DATA_W (RSP_W)
   ) u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (rsp_word),
      .full      (req_stall),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

   assign {rsp_update, rsp_shown, rsp_selected} = rsp_data;

   assign rsp_update_flag     = rsp_update;
   assign rsp_shown_current_a = rsp_shown[SMP_CURRENT_A];
   assign rsp_shown_current_b = rsp_shown[SMP_CURRENT_B];
   assign rsp_shown_voltage_a = rsp_shown[SMP_VOLTAGE_A];
   assign rsp_shown_voltage_b = rsp_shown[SMP_VOLTAGE_B];
   assign rsp_short_average   = rsp_selected[LANE_SHORT];
   assign rsp_medium_average  = rsp_selected[LANE_MEDIUM];
   assign rsp_long_average    = rsp_selected[LANE_LONG];
   assign rsp_peak_current    = rsp_selected[LANE_PEAK];

endmodule
